### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, held off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ufr_pkg.sv
package ufr_pkg;

    // register indexes of the configuration port
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 1'b1;

    localparam logic [7:0]  START_BYTE_RESET = 8'd170;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd100;

    // crc-8/smbus
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;
    localparam logic [3:0] CRC_SPAN   = 4'd10;
    localparam int unsigned ADDR_BYTES = 6;

    typedef enum logic {
        K_BYTE = 1'b0,
        K_TICK = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic {
        S_HUNT    = 1'b0,
        S_COLLECT = 1'b1
    } t_rx_state;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // classified item passed from front to back
    typedef struct packed {
        t_kind      kind;
        logic       is_start;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        t_status                 status;
        logic [8*ADDR_BYTES-1:0] address;
        logic [7:0]              command;
        logic [7:0]              payload;
    } t_result;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hdl/uart_frame_receiver_crc8_top.sv
// channel   | handshake        | fields
// ----------+------------------+----------------------------------------------
// input     | push / full      | i_opcode, i_rx_byte
// result    | empty / pop      | o_status, o_address, o_command, o_payload
// config    | i_cfg_we         | i_cfg_index, i_cfg_data
//
// one item per cycle sustained; the back end retires one queued item per cycle
// while the result queue is not full, writing into that queue the result of each
// item that closes a frame, whose result then shows on the ports until popped
// reset is synchronous, active low, and empties both queues
// full rises only when the item queue fills, which happens when the result
// queue is full and pop stays low
module uart_frame_receiver_crc8_top
    import ufr_pkg::*;
#(
    parameter int unsigned CMD_DEPTH = 4,
    parameter int unsigned RES_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_opcode,
    input  logic [7:0]            i_rx_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_status,
    output logic [47:0]           o_address,
    output logic [7:0]            o_command,
    output logic [7:0]            o_payload,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg_wr cfg;
    t_cmd    front_cmd;
    t_cmd    q_cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_full;
    logic    res_push;
    t_result back_res;
    t_result q_res;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // front: register start byte and classify items
    ufr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_opcode  (i_opcode),
        .i_rx_byte (i_rx_byte),
        .o_cmd     (front_cmd)
    );

    // item queue between front and back
    ufr_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (q_cmd),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    // back: frame assembly, crc check and timeout
    ufr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // result queue toward the consumer
    ufr_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (q_res),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_status  = q_res.status;
    assign o_address = q_res.address;
    assign o_command = q_res.command;
    assign o_payload = q_res.payload;

endmodule

### hdl/ufr_fifo.sv
module ufr_fifo #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/ufr_front.sv
module ufr_front
    import ufr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_wr    i_cfg,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    output t_cmd       o_cmd
);

    logic [7:0] r_start_byte;

    // start byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RESET;
        end else if (i_cfg.we && (i_cfg.index == REG_START_BYTE)) begin
            r_start_byte <= i_cfg.data[7:0];
        end
    end

    // classify the item: tick or byte, and whether the byte opens a frame
    always_comb begin
        o_cmd.kind     = i_opcode ? K_TICK : K_BYTE;
        o_cmd.is_start = (i_rx_byte == r_start_byte);
        o_cmd.data     = i_rx_byte;
    end

endmodule

### hdl/ufr_back.sv
module ufr_back
    import ufr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    t_rx_state                r_state, n_state;
    logic [3:0]               r_byte_index, n_byte_index;
    logic [7:0]               r_crc, n_crc;
    logic [8*ADDR_BYTES-1:0]  r_address, n_address;
    logic [7:0]               r_command, n_command;
    logic [7:0]               r_payload, n_payload;
    logic [15:0]              r_tick_count, n_tick_count;
    logic [15:0]              r_timeout;
    logic [15:0]              limit;
    logic [15:0]              tick_inc;
    logic [7:0]               crc_next;
    logic                     fire;
    logic                     timed_out;
    logic                     frame_end;

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg.we && (i_cfg.index == REG_TIMEOUT)) begin
            r_timeout <= i_cfg.data;
        end
    end

    assign fire      = i_cmd_valid && !i_res_full;
    assign o_cmd_pop = fire;

    // shared datapath terms
    assign limit     = (r_timeout == '0) ? 16'd1 : r_timeout;
    assign tick_inc  = (r_tick_count == 16'hFFFF) ? r_tick_count : r_tick_count + 16'd1;
    assign timed_out = (tick_inc >= limit);
    assign crc_next  = crc8_step((r_state == S_HUNT) ? CRC_INIT : r_crc, i_cmd.data);
    assign frame_end = (r_byte_index >= CRC_SPAN);

    // next state
    always_comb begin
        n_state = r_state;
        if (fire) begin
            unique case (r_state)
                S_HUNT: begin
                    if (i_cmd.kind == K_BYTE && i_cmd.is_start) begin
                        n_state = S_COLLECT;
                    end
                end
                S_COLLECT: begin
                    if (i_cmd.kind == K_TICK) begin
                        if (timed_out) begin
                            n_state = S_HUNT;
                        end
                    end else if (frame_end) begin
                        n_state = S_HUNT;
                    end
                end
                default: n_state = S_HUNT;
            endcase
        end
    end

    // frame registers and result
    always_comb begin
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_address    = r_address;
        n_command    = r_command;
        n_payload    = r_payload;
        n_tick_count = r_tick_count;
        o_res_push   = 1'b0;
        o_res.status = ST_GOOD;
        o_res.address = '0;
        o_res.command = '0;
        o_res.payload = '0;
        if (fire) begin
            unique case (r_state)
                S_HUNT: begin
                    if (i_cmd.kind == K_BYTE && i_cmd.is_start) begin
                        n_byte_index = 4'd1;
                        n_crc        = crc_next;
                        n_address    = '0;
                        n_command    = '0;
                        n_payload    = '0;
                        n_tick_count = '0;
                    end
                end
                S_COLLECT: begin
                    if (i_cmd.kind == K_TICK) begin
                        n_tick_count = tick_inc;
                        if (timed_out) begin
                            o_res_push   = 1'b1;
                            o_res.status = ST_TIMEOUT;
                            n_byte_index = '0;
                        end
                    end else if (frame_end) begin
                        o_res_push   = 1'b1;
                        n_byte_index = '0;
                        if (r_crc == i_cmd.data) begin
                            o_res.status  = ST_GOOD;
                            o_res.address = r_address;
                            o_res.command = r_command;
                            o_res.payload = r_payload;
                        end else begin
                            o_res.status = ST_CRC_ERR;
                        end
                    end else begin
                        n_crc        = crc_next;
                        n_byte_index = r_byte_index + 4'd1;
                        for (int k = 0; k < ADDR_BYTES; k++) begin
                            if (r_byte_index == 4'(k + 2)) begin
                                n_address[8*k +: 8] = i_cmd.data;
                            end
                        end
                        if (r_byte_index == 4'd8) begin
                            n_command = i_cmd.data;
                        end
                        if (r_byte_index == 4'd9) begin
                            n_payload = i_cmd.data;
                        end
                    end
                end
                default: n_byte_index = '0;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_HUNT;
            r_byte_index <= '0;
            r_tick_count <= '0;
        end else begin
            r_state      <= n_state;
            r_byte_index <= n_byte_index;
            r_tick_count <= n_tick_count;
        end
    end

    // frame payload registers; address, command and payload are cleared when a frame starts
    always_ff @(posedge i_clk) begin
        r_crc     <= n_crc;
        r_address <= n_address;
        r_command <= n_command;
        r_payload <= n_payload;
    end

endmodule

### hdl/ufr_checker.sv
`include "assert_macros.svh"

module ufr_checker
    import ufr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [47:0] o_address,
    input logic [7:0]  o_command,
    input logic [7:0]  o_payload
);

    logic        status_known;
    logic        error_head;
    logic        fields_zero;
    logic        stalled;
    logic [65:0] head;

    // terms seen on the result ports
    assign status_known = (o_status == ST_GOOD) || (o_status == ST_CRC_ERR) ||
                          (o_status == ST_TIMEOUT);
    assign error_head   = !empty && (o_status != ST_GOOD);
    assign fields_zero  = (o_address == '0) && (o_command == '0) && (o_payload == '0);
    assign stalled      = !empty && !pop;
    assign head         = {o_status, o_address, o_command, o_payload};

    property p_result_holds;
        stalled |=> (!empty && $stable(head));
    endproperty

    // only defined status codes are shown
    `ASSERT_CLK(a_status_code, i_clk, i_rst_n, !empty |-> status_known, "undefined status code")

    // failed frames carry zero fields
    `ASSERT_CLK(a_error_zero, i_clk, i_rst_n, error_head |-> fields_zero, "error fields not zero")

    // a waiting result holds until taken
    `ASSERT_CLK(a_result_holds, i_clk, i_rst_n, p_result_holds, "waiting result changed")

    // reset leaves the result queue empty and the item queue not full
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (empty && !full), "item left after reset")

endmodule

bind uart_frame_receiver_crc8_top ufr_checker u_ufr_checker (.*);

### verif/uart_frame_receiver_crc8_top_tb.sv
module uart_frame_receiver_crc8_top_tb
    import ufr_pkg::*;
();

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned GAP_PCT      = 18;
    localparam logic [7:0]  CRC8_POLY    = 8'h07;
    localparam int unsigned FRAME_LEN    = 11;

    // directed row kinds and how each row is checked
    typedef enum logic [2:0] {
        R_BYTE,
        R_TICK,
        R_CRC_OK,
        R_CRC_BAD,
        R_SET_TMO
    } t_row_op;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_FIXED
    } t_chk;

    typedef struct packed {
        t_row_op    op;
        logic [7:0] val;
        t_chk       chk;
        t_status    st;
    } t_dir_row;

    localparam int unsigned DIR_ROWS = 26;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // good frame at reset settings, start byte value inside the address
        '{R_BYTE,    8'hAA, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h0B, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h00, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'hFF, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h01, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h80, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h7F, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'hAA, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'hFF, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h00, CHK_MODEL, ST_GOOD},
        '{R_CRC_OK,  8'h00, CHK_MODEL, ST_GOOD},
        // tick while hunting is dropped
        '{R_TICK,    8'hFF, CHK_NONE,  ST_GOOD},
        // bad crc, fields read back as zero
        '{R_BYTE,    8'hAA, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h00, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h12, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h34, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h56, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h78, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h9A, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'hBC, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'h0F, CHK_MODEL, ST_GOOD},
        '{R_BYTE,    8'hF0, CHK_MODEL, ST_GOOD},
        '{R_CRC_BAD, 8'h00, CHK_FIXED, ST_CRC_ERR},
        // zero timeout acts as one tick
        '{R_SET_TMO, 8'h00, CHK_NONE,  ST_GOOD},
        '{R_BYTE,    8'hAA, CHK_MODEL, ST_GOOD},
        '{R_TICK,    8'h00, CHK_FIXED, ST_TIMEOUT}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic                  i_opcode;
    logic [7:0]            i_rx_byte;
    logic                  empty;
    logic                  pop;
    logic [1:0]            o_status;
    logic [47:0]           o_address;
    logic [7:0]            o_command;
    logic [7:0]            o_payload;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // receiver copy: settings and frame state
    logic [7:0]  sof_byte;
    logic [15:0] tick_limit;
    bit          in_frame;
    logic [3:0]  frame_pos;
    logic [7:0]  crc_acc;
    logic [47:0] addr_acc;
    logic [7:0]  cmd_acc;
    logic [7:0]  pay_acc;
    logic [15:0] ticks_seen;

    t_result     expected_reports [$];
    t_result     want;
    t_result     fixed_rep;
    int unsigned mismatch_cnt;
    int unsigned live_items;
    int unsigned cycle_cnt = 0;
    bit          gaps_on;

    uart_frame_receiver_crc8_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_opcode    (i_opcode),
        .i_rx_byte   (i_rx_byte),
        .empty       (empty),
        .pop         (pop),
        .o_status    (o_status),
        .o_address   (o_address),
        .o_command   (o_command),
        .o_payload   (o_payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // crc-8/smbus, one bit at a time, msb first
    function automatic logic [7:0] crc8_smbus_next(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ d[i];
            r = {r[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic clear_frame();
        in_frame   = 1'b0;
        frame_pos  = '0;
        crc_acc    = '0;
        addr_acc   = '0;
        cmd_acc    = '0;
        pay_acc    = '0;
        ticks_seen = '0;
    endtask

    // advance the receiver copy by one item
    task automatic rx_predict(input t_kind k, input logic [7:0] b, output bit got,
                              output t_result rep, output bit ignored);
        logic [15:0] lim;
        got = 1'b0;
        ignored = 1'b0;
        rep = '0;
        if (k == K_TICK) begin
            if (!in_frame) begin
                ignored = 1'b1;
            end else begin
                lim = (tick_limit == 16'd0) ? 16'd1 : tick_limit;
                if (ticks_seen != 16'hFFFF) ticks_seen = ticks_seen + 16'd1;
                if (ticks_seen >= lim) begin
                    clear_frame();
                    rep.status = ST_TIMEOUT;
                    got = 1'b1;
                end
            end
        end else if (!in_frame) begin
            if (b == sof_byte) begin
                clear_frame();
                in_frame  = 1'b1;
                frame_pos = 4'd1;
                crc_acc   = crc8_smbus_next(8'h00, b);
            end else begin
                ignored = 1'b1;
            end
        end else if (frame_pos < 4'd10) begin
            crc_acc = crc8_smbus_next(crc_acc, b);
            if (frame_pos >= 4'd2 && frame_pos <= 4'd7)
                addr_acc[(frame_pos - 4'd2) * 8 +: 8] = b;
            else if (frame_pos == 4'd8)
                cmd_acc = b;
            else if (frame_pos == 4'd9)
                pay_acc = b;
            frame_pos = frame_pos + 4'd1;
        end else begin
            // crc byte closes the frame
            if (crc_acc == b) begin
                rep.status  = ST_GOOD;
                rep.address = addr_acc;
                rep.command = cmd_acc;
                rep.payload = pay_acc;
            end else begin
                rep.status = ST_CRC_ERR;
            end
            clear_frame();
            got = 1'b1;
        end
    endtask

    // offer one item, with random gaps while gaps are on, until it is taken
    task automatic put_item(input t_kind k, input logic [7:0] b, input bit from_model);
        bit      got;
        bit      ignored;
        t_result rep;
        while (gaps_on && $urandom_range(99) < GAP_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_opcode  <= k;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        rx_predict(k, b, got, rep, ignored);
        if (!ignored) live_items++;
        if (got && from_model) expected_reports.push_back(rep);
    endtask

    // hold off input until every report is back and the pipe is quiet
    task automatic settle();
        push <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_START_BYTE) sof_byte = data[7:0];
        else tick_limit = data;
        @(posedge i_clk);
    endtask

    // one frame with random content; stop_at < 11 leaves it broken off
    task automatic send_frame(input int tick_pct, input int stop_at);
        logic [7:0] fb [FRAME_LEN];
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (i == 0)
                fb[i] = sof_byte;
            else if (i == FRAME_LEN - 1)
                fb[i] = ($urandom_range(99) < 20) ? acc ^ 8'($urandom_range(1, 255)) : acc;
            else
                fb[i] = ($urandom_range(9) == 0) ? sof_byte : 8'($urandom);
            if (i < FRAME_LEN - 1) acc = crc8_smbus_next(acc, fb[i]);
        end
        for (int i = 0; i < stop_at; i++) begin
            if (i > 0 && $urandom_range(99) < tick_pct) put_item(K_TICK, 8'($urandom), 1'b1);
            put_item(K_BYTE, fb[i], 1'b1);
        end
    endtask

    // one random phase under fixed settings
    task automatic run_phase(input logic [7:0] sb, input logic [15:0] tmo, input int n,
                             input bit gaps, input int tick_pct);
        int unsigned first;
        int unsigned pick;
        int unsigned cnt;
        settle();
        write_reg(REG_START_BYTE, {8'h00, sb});
        write_reg(REG_TIMEOUT, tmo);
        gaps_on = gaps;
        first = live_items;
        while (live_items - first < n) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(tick_pct, FRAME_LEN);
            end else if (pick < 78) begin
                send_frame(tick_pct, $urandom_range(1, FRAME_LEN - 1));
            end else if (pick < 88) begin
                cnt = $urandom_range(1, 4);
                repeat (cnt) put_item(K_BYTE, 8'($urandom), 1'b1);
            end else if (pick < 95 || tick_limit > 16'd200) begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) put_item(K_TICK, 8'($urandom), 1'b1);
            end else begin
                // start a frame and let it run out of time
                put_item(K_BYTE, sof_byte, 1'b1);
                cnt = $urandom_range(1, int'(tick_limit) + 2);
                repeat (cnt) put_item(K_TICK, 8'($urandom), 1'b1);
            end
        end
    endtask

    // stimulus
    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_opcode    <= K_BYTE;
        i_rx_byte   <= 8'h00;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_START_BYTE;
        i_cfg_data  <= '0;
        sof_byte     = START_BYTE_RESET;
        tick_limit   = TIMEOUT_RESET;
        mismatch_cnt = 0;
        live_items   = 0;
        gaps_on      = 1'b1;
        clear_frame();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int r = 0; r < DIR_ROWS; r++) begin
            unique case (DIRECTED[r].op)
                R_SET_TMO: begin
                    settle();
                    write_reg(REG_TIMEOUT, {8'h00, DIRECTED[r].val});
                end
                R_TICK: begin
                    put_item(K_TICK, DIRECTED[r].val, DIRECTED[r].chk == CHK_MODEL);
                end
                R_CRC_OK: begin
                    put_item(K_BYTE, crc_acc, DIRECTED[r].chk == CHK_MODEL);
                end
                R_CRC_BAD: begin
                    put_item(K_BYTE, crc_acc ^ 8'h5A, DIRECTED[r].chk == CHK_MODEL);
                end
                default: begin
                    put_item(K_BYTE, DIRECTED[r].val, DIRECTED[r].chk == CHK_MODEL);
                end
            endcase
            if (DIRECTED[r].chk == CHK_FIXED) begin
                fixed_rep = '0;
                fixed_rep.status = DIRECTED[r].st;
                expected_reports.push_back(fixed_rep);
            end
        end

        // random phases, extremes of both registers among them
        run_phase(START_BYTE_RESET, TIMEOUT_RESET, 300, 1'b1, 5);
        run_phase(8'h00, 16'd1, 250, 1'b1, 3);
        run_phase(8'hFF, 16'd0, 200, 1'b1, 3);
        run_phase(8'($urandom), 16'hFFFF, 350, 1'b0, 20);
        run_phase(8'($urandom), 16'($urandom_range(3, 40)), 600, 1'b1, 12);

        // drain and report
        settle();
        if (mismatch_cnt == 0 && expected_reports.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // report side: random pop, compare each taken report
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_reports.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected report: st=%0d addr=%h cmd=%h pay=%h",
                                 o_status, o_address, o_command, o_payload);
                end else begin
                    want = expected_reports.pop_front();
                    if (o_status !== want.status || o_address !== want.address ||
                        o_command !== want.command || o_payload !== want.payload) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp %0d %h %h %h, got %0d %h %h %h",
                                     want.status, want.address, want.command,
                                     want.payload, o_status, o_address, o_command,
                                     o_payload);
                    end
                end
            end
            pop <= !(gaps_on && $urandom_range(99) < GAP_PCT);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

### filelist.f
+incdir+hdl
hdl/ufr_pkg.sv
hdl/ufr_fifo.sv
hdl/ufr_front.sv
hdl/ufr_back.sv
hdl/uart_frame_receiver_crc8_top.sv
hdl/ufr_checker.sv
verif/uart_frame_receiver_crc8_top_tb.sv
